### rtl/assert_macros.svh
// assertion macros used by binary_max_heap_queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BHQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BHQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bhq_pkg.sv
package bhq_pkg;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

endpackage

### rtl/bhq_if.sv
// request channel
interface bhq_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

// result channel
interface bhq_rsp_if #(
    parameter int CNT_W = 5
);
    logic               valid;
    logic               ready;
    logic signed [31:0] removed_value;
    logic signed [31:0] top_value;
    logic [CNT_W-1:0]   count;
    logic [1:0]         status;

    modport source (output valid, output removed_value, output top_value, output count,
                    output status, input ready);
    modport sink   (input valid, input removed_value, input top_value, input count,
                    input status, output ready);
endinterface

### rtl/bhq_ram.sv
module bhq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic signed [31:0] wdata,
    input  logic [AW-1:0]      raddr_a,
    input  logic [AW-1:0]      raddr_b,
    output logic signed [31:0] rdata_a,
    output logic signed [31:0] rdata_b
);

    logic signed [31:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/binary_max_heap_queue.sv
// binary max-heap priority queue, one request word in, one result word out;
// an insert sifts its value up from the end toward the root, a delete refills the root
// from the last entry and sifts it down toward a leaf, and a delete that empties the heap
// goes straight to the result; a new request is taken only once the last result is loaded
// reset: rst_n async low clears the count, sequencer and result valid; heap memory is not
// cleared, entries at or above the count are never used
module binary_max_heap_queue #(
    parameter int CAPACITY = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    bhq_req_if.sink          req,
    bhq_rsp_if.source        rsp
);

    import bhq_pkg::*;

    `include "assert_macros.svh"

    // index width, count width and child index width
    localparam int AW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int CW = AW + 1;

    // sequencer state
    state_t             state_reg, state_next;
    // current hole position in the heap
    logic [AW-1:0]      pos_reg, pos_next;
    // number of stored values
    logic [NW-1:0]      n_reg, n_next;
    // value being sifted
    logic signed [31:0] mov_reg, mov_next;
    // removed maximum of the request in flight
    logic signed [31:0] rem_reg, rem_next;
    // shadow copy of the root entry
    logic signed [31:0] top_reg, top_next;
    status_t            status_reg, status_next;

    // result register
    logic               out_valid_reg;
    logic signed [31:0] out_removed_reg;
    logic signed [31:0] out_top_reg;
    logic [NW-1:0]      out_count_reg;
    status_t            out_status_reg;
    logic               out_load;

    // memory port
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic [AW-1:0]      mem_raddr_a;
    logic [AW-1:0]      mem_raddr_b;
    logic signed [31:0] mem_rdata_a;
    logic signed [31:0] mem_rdata_b;

    // heap index arithmetic
    logic [AW-1:0]      parent_idx;
    logic [CW-1:0]      lchild_w;
    logic [CW-1:0]      rchild_w;
    logic [NW-1:0]      n_dec;
    logic               in_accept;

    // child compare during sift-down
    logic               go_l;
    logic               go_r;
    logic               r_ok;
    logic signed [31:0] best_v;

    assign parent_idx = (pos_reg - 1'b1) >> 1;
    assign lchild_w   = {pos_reg, 1'b1};
    assign rchild_w   = lchild_w + 1'b1;
    assign n_dec      = n_reg - 1'b1;
    assign in_accept  = req.valid && req.ready;

    assign go_l   = mem_rdata_a > mov_reg;
    assign best_v = go_l ? mem_rdata_a : mov_reg;
    assign r_ok   = rchild_w < CW'(n_reg);
    assign go_r   = r_ok && (mem_rdata_b > best_v);

    // the sequence never uses a read of an entry in the cycle it is written: a write always
    // lands on the hole, and the next read goes to its parent or children

    bhq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            n_reg      <= '0;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            status_reg <= status_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        mov_reg <= mov_next;
        rem_reg <= rem_next;
        top_reg <= top_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        n_next      = n_reg;
        mov_next    = mov_reg;
        rem_next    = rem_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = mov_reg;
        mem_raddr_a = '0;
        mem_raddr_b = '0;
        out_load    = 1'b0;
        req.ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // ready is high throughout idle, so valid alone marks the accept
                req.ready = 1'b1;
                if (req.valid)
                begin
                    rem_next    = '0;
                    status_next = ST_DONE;
                    if (req.req_type == REQ_INSERT)
                    begin
                        if (n_reg == NW'(CAPACITY))
                        begin
                            // full heap: refuse, nothing changes
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            // hole opens at the end
                            pos_next   = n_reg[AW-1:0];
                            mov_next   = req.value;
                            n_next     = n_reg + 1'b1;
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (n_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            rem_next = top_reg;
                            n_next   = n_dec;
                            pos_next = '0;
                            if (n_dec == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                // fetch the last entry, it refills the root
                                mem_raddr_a = AW'(n_dec);
                                state_next  = S_DN_LAST;
                            end
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr_a = parent_idx;
                    state_next  = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (mem_rdata_a < mov_reg)
                begin
                    // parent moves down into the hole
                    mem_wdata  = mem_rdata_a;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DN_LAST:
            begin
                mov_next   = mem_rdata_a;
                state_next = S_DN_RD;
            end

            S_DN_RD:
            begin
                if (lchild_w >= CW'(n_reg))
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr_a = lchild_w[AW-1:0];
                    mem_raddr_b = rchild_w[AW-1:0];
                    state_next  = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (go_r)
                begin
                    // right child wins only when strictly above left and the value
                    mem_wdata  = mem_rdata_b;
                    pos_next   = rchild_w[AW-1:0];
                    state_next = S_DN_RD;
                end
                else if (go_l)
                begin
                    mem_wdata  = mem_rdata_a;
                    pos_next   = lchild_w[AW-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // root shadow follows every write to entry zero
    always_comb
    begin
        top_next = top_reg;
        if (mem_we && (mem_waddr == '0))
        begin
            top_next = mem_wdata;
        end
    end

    // result register, a new request may enter while a result waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_removed_reg <= rem_reg;
            out_top_reg     <= (n_reg == '0) ? 32'sd0 : top_reg;
            out_count_reg   <= n_reg;
            out_status_reg  <= status_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.removed_value = out_removed_reg;
    assign rsp.top_value     = out_top_reg;
    assign rsp.count         = out_count_reg;
    assign rsp.status        = out_status_reg;

    // checks
    `BHQ_ASSERT_IMP(a_count_bound, 1'b1, n_reg <= NW'(CAPACITY), "count above capacity")
    `BHQ_ASSERT_IMP(a_idle_no_write, state_reg == S_IDLE, !mem_we, "memory write while idle")
    `BHQ_ASSERT_NXT(a_insert_count,
        in_accept && (req.req_type == REQ_INSERT) && (n_reg != NW'(CAPACITY)),
        n_reg == $past(n_reg) + 1'b1, "insert did not grow the count")
    `BHQ_ASSERT_IMP(a_load_free, out_load, !out_valid_reg || rsp.ready,
        "result overwritten before taken")

endmodule
